### hw/rtl/pid_controller_clamped_macros.svh
// assertion macros used by the checker file
`ifndef PID_CONTROLLER_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define PIDC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pidc check failed");

// next-cycle implication, quiet while reset is high
`define PIDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pidc check failed");

`endif

### hw/rtl/pidc_pkg.sv
package pidc_pkg;

   // register indexes on the configuration port
   localparam logic [1:0] REG_GAIN_PROP   = 2'd0;
   localparam logic [1:0] REG_GAIN_INTEG  = 2'd1;
   localparam logic [1:0] REG_GAIN_DERIV  = 2'd2;
   localparam logic [1:0] REG_INTEG_LIMIT = 2'd3;

   localparam logic [14:0]        INTEG_LIMIT_RESET = 15'd25600;
   localparam logic [14:0]        DRIVE_MAX         = 15'd25600;
   // 6554 / 65536 stands for one tenth
   localparam logic signed [14:0] TENTH_Q16         = 15'sd6554;

   typedef struct packed {
      logic [15:0] gain_prop;
      logic [15:0] gain_integ;
      logic [15:0] gain_deriv;
      logic [14:0] integ_limit;
   } cfg_type;

   typedef struct packed {
      logic load;        // capture the error of a new item
      logic prop_step;   // kp * e, derivative difference, save error
      logic integ_step;  // ki * e
      logic tenth_step;  // scale by one tenth, kd * 10 * de
      logic acc_step;    // update and clamp the integral
      logic out_load;    // sum, saturate, load output register
   } cmd_type;

   typedef struct packed {
      logic out_free;    // output register can take a new result
   } stat_type;

endpackage

### hw/rtl/pidc_regs.sv
module pidc_regs (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output pidc_pkg::cfg_type cfg
);

   logic [15:0] gain_prop_ff;
   logic [15:0] gain_integ_ff;
   logic [15:0] gain_deriv_ff;
   logic [14:0] integ_limit_ff;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff   <= '0;
         gain_integ_ff  <= '0;
         gain_deriv_ff  <= '0;
         integ_limit_ff <= pidc_pkg::INTEG_LIMIT_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            pidc_pkg::REG_GAIN_PROP:   gain_prop_ff   <= csr_pwdata[15:0];
            pidc_pkg::REG_GAIN_INTEG:  gain_integ_ff  <= csr_pwdata[15:0];
            pidc_pkg::REG_GAIN_DERIV:  gain_deriv_ff  <= csr_pwdata[15:0];
            pidc_pkg::REG_INTEG_LIMIT: integ_limit_ff <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         pidc_pkg::REG_GAIN_PROP:   csr_prdata = {16'd0, gain_prop_ff};
         pidc_pkg::REG_GAIN_INTEG:  csr_prdata = {16'd0, gain_integ_ff};
         pidc_pkg::REG_GAIN_DERIV:  csr_prdata = {16'd0, gain_deriv_ff};
         pidc_pkg::REG_INTEG_LIMIT: csr_prdata = {17'd0, integ_limit_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   assign cfg.gain_prop   = gain_prop_ff;
   assign cfg.gain_integ  = gain_integ_ff;
   assign cfg.gain_deriv  = gain_deriv_ff;
   assign cfg.integ_limit = integ_limit_ff;

endmodule

### hw/rtl/pidc_ctrl.sv
module pidc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  pidc_pkg::stat_type stat,
   output pidc_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PROP  = 6'b000010,
      ST_INTEG = 6'b000100,
      ST_TENTH = 6'b001000,
      ST_ACC   = 6'b010000,
      ST_SUM   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // sequencing and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PROP;
            end
         end
         ST_PROP: begin
            cmd.prop_step = 1'b1;
            state_in      = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.integ_step = 1'b1;
            state_in       = ST_TENTH;
         end
         ST_TENTH: begin
            cmd.tenth_step = 1'b1;
            state_in       = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_step = 1'b1;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            // hold here while the previous result is still waiting
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/pidc_datapath.sv
module pidc_datapath (
   input  logic               clock,
   input  logic               reset,
   input  pidc_pkg::cfg_type  cfg,
   input  pidc_pkg::cmd_type  cmd,
   output pidc_pkg::stat_type stat,
   input  logic [15:0]        set_temp,
   input  logic [15:0]        measured_temp,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [14:0]        drive_level
);

   logic signed [16:0] err_ff;
   logic signed [16:0] prev_ff;
   logic signed [21:0] dd_ff;
   logic signed [28:0] prop_ff;
   logic signed [32:0] pi_ff;
   logic signed [26:0] inc_ff;
   logic signed [33:0] deriv_ff;
   logic signed [16:0] acc_ff;
   logic               rsp_valid_ff;
   logic [14:0]        drive_ff;

   logic signed [16:0] err_in;
   logic signed [17:0] diff;
   logic signed [21:0] diff_ext;
   logic signed [21:0] dd_in;
   logic [15:0]        gain_sel;
   logic signed [21:0] op_sel;
   logic signed [38:0] mul_res;
   logic signed [47:0] tenth_res;
   logic signed [27:0] acc_sum;
   logic signed [27:0] lim_pos;
   logic signed [27:0] lim_neg;
   logic signed [16:0] acc_in;
   logic signed [35:0] sum;
   logic [14:0]        drive_in;

   // error of the incoming item, exact in 17 bits
   assign err_in = $signed({set_temp[15], set_temp})
                 - $signed({measured_temp[15], measured_temp});

   // ten times the change in error, as 8x + 2x
   assign diff     = $signed({err_ff[16], err_ff}) - $signed({prev_ff[16], prev_ff});
   assign diff_ext = {{4{diff[17]}}, diff};
   assign dd_in    = (diff_ext <<< 3) + (diff_ext <<< 1);

   // shared gain multiplier
   always_comb begin
      if (cmd.prop_step) begin
         gain_sel = cfg.gain_prop;
      end else if (cmd.integ_step) begin
         gain_sel = cfg.gain_integ;
      end else begin
         gain_sel = cfg.gain_deriv;
      end
      if (cmd.tenth_step) begin
         op_sel = dd_ff;
      end else begin
         op_sel = {{5{err_ff[16]}}, err_ff};
      end
   end

   assign mul_res   = $signed({1'b0, gain_sel}) * op_sel;
   assign tenth_res = pi_ff * pidc_pkg::TENTH_Q16;

   // integral update and clamp to +/- limit
   assign acc_sum = {{11{acc_ff[16]}}, acc_ff} + {inc_ff[26], inc_ff};
   assign lim_pos = $signed({13'd0, cfg.integ_limit});
   assign lim_neg = -lim_pos;

   always_comb begin
      if (acc_sum > lim_pos) begin
         acc_in = lim_pos[16:0];
      end else if (acc_sum < lim_neg) begin
         acc_in = lim_neg[16:0];
      end else begin
         acc_in = acc_sum[16:0];
      end
   end

   // final sum and output saturation
   assign sum = {{7{prop_ff[28]}}, prop_ff} + {{19{acc_ff[16]}}, acc_ff}
              + {{2{deriv_ff[33]}}, deriv_ff};

   always_comb begin
      if (sum > $signed({21'd0, pidc_pkg::DRIVE_MAX})) begin
         drive_in = pidc_pkg::DRIVE_MAX;
      end else if (sum < 0) begin
         drive_in = '0;
      end else begin
         drive_in = sum[14:0];
      end
   end

   // term registers, floor shifts are bit selects
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         err_ff <= err_in;
      end
      if (cmd.prop_step) begin
         prop_ff <= mul_res[32:4];
         dd_ff   <= dd_in;
      end
      if (cmd.integ_step) begin
         pi_ff <= mul_res[32:0];
      end
      if (cmd.tenth_step) begin
         inc_ff   <= tenth_res[46:20];
         deriv_ff <= mul_res[37:4];
      end
      if (cmd.out_load) begin
         drive_ff <= drive_in;
      end
   end

   // controller state carried between items
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         acc_ff  <= '0;
      end else begin
         if (cmd.prop_step) begin
            prev_ff <= err_ff;
         end
         if (cmd.acc_step) begin
            acc_ff <= acc_in;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign drive_level   = drive_ff;

endmodule

### hw/rtl/pid_controller_clamped.sv
// channel    ports     direction  payload
// req        req_*     in         set_temp, measured_temp
// rsp        rsp_*     out        drive_level
// csr        csr_*     in         gain_prop, gain_integ, gain_deriv, integ_limit
//
// an item steps through the prop, integ, tenth, acc and sum states from the req
// transfer to rsp_tvalid; the next item is taken in the cycle after the result
// is loaded; one item at a time: the sequencer steps one shared gain multiplier
// reset clears the sequencer, integral, stored error, rsp_tvalid and the gains
// a stalled rsp holds the finished item in the last step until the output frees
module pid_controller_clamped (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] set_temp, [31:16] measured_temp
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [14:0] drive_level, [15] zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   pidc_pkg::cfg_type  cfg;
   pidc_pkg::cmd_type  cmd;
   pidc_pkg::stat_type stat;
   logic [14:0]        drive_level;

   pidc_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pidc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pidc_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .stat          (stat),
      .set_temp      (req_tdata[15:0]),
      .measured_temp (req_tdata[31:16]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .drive_level   (drive_level)
   );

   assign rsp_tdata = {1'b0, drive_level};

endmodule

### hw/rtl/pidc_checker.sv
`include "pid_controller_clamped_macros.svh"

module pidc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // drive never exceeds full scale
   `PIDC_ASSERT_NOW(a_drive_range, clock, reset, rsp_tvalid, (rsp_tdata <= 16'd25600))

   // one item at a time: no input transfer right after another
   `PIDC_ASSERT_NEXT(a_one_item, clock, reset, (req_tvalid && req_tready), !req_tready)

   // a result never appears the cycle after its input transfer
   `PIDC_ASSERT_NEXT(a_latency, clock, reset, (req_tvalid && req_tready), !$rose(rsp_tvalid))

   // a stalled result stays put
   `PIDC_ASSERT_NEXT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready), (rsp_tvalid && $stable(rsp_tdata)))

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (.*);

### bench/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int PIPE_CYCLES  = 8;     // req transfer to rsp_tvalid, with margin
   localparam int HOLD_CYCLES  = 300;   // long rsp back-pressure stretch
   localparam int QUIET_LIMIT  = 3000;  // cycles with no transfer before giving up
   localparam int MAX_GAP      = 12;
   localparam int PHASE_COUNT  = 16;
   localparam int PHASE_ITEMS  = 95;
   localparam int MODE_RUN     = 50;    // items between idle-mode changes

   // one row of the directed plan: a register write or a pair of temperatures
   typedef struct packed {
      logic        is_cfg;
      logic [1:0]  reg_idx;
      logic [31:0] value;
      logic [15:0] tgt;
      logic [15:0] meas;
      logic        fixed;
      logic [14:0] drive;
   } step_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [15:0] set_temp, [31:16] measured_temp
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [14:0] drive_level, [15] zero
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pid_controller_clamped dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // controller model state and register shadow
   pidc_pkg::cfg_type gains_model = '{16'd0, 16'd0, 16'd0, pidc_pkg::INTEG_LIMIT_RESET};
   longint      acc_model = 0;
   longint      err_prev_model = 0;

   logic [14:0] drive_expected [$];
   step_type    plan [$];

   logic        pending_fixed;
   logic [14:0] pending_drive;
   logic [14:0] drive_want;
   logic [14:0] drive_calc;
   logic        snd_nostall;
   logic        rsp_nostall;
   logic        hold_request;
   int          fail_count = 0;
   int          mismatch_count = 0;
   int          quiet_cycles;
   int          setpoint;
   int          process_val;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // heater drive for one tick; advances the integral and stored error
   function automatic logic [14:0] next_drive(input logic signed [15:0] tgt,
                                              input logic signed [15:0] meas);
      longint err;
      longint lim;
      longint prop;
      longint inc;
      longint deriv;
      longint sum;
      err  = longint'(tgt) - longint'(meas);
      lim  = longint'(gains_model.integ_limit);
      prop = (longint'(gains_model.gain_prop) * err) >>> 4;
      inc  = (longint'(gains_model.gain_integ) * err * longint'(pidc_pkg::TENTH_Q16)) >>> 20;
      acc_model = acc_model + inc;
      if (acc_model > lim)
         acc_model = lim;
      else if (acc_model < -lim)
         acc_model = -lim;
      deriv = (longint'(gains_model.gain_deriv) * 10 * (err - err_prev_model)) >>> 4;
      err_prev_model = err;
      sum = prop + acc_model + deriv;
      if (sum > longint'(pidc_pkg::DRIVE_MAX))
         sum = longint'(pidc_pkg::DRIVE_MAX);
      else if (sum < 0)
         sum = 0;
      return sum[14:0];
   endfunction

   function automatic step_type cfg_row(input logic [1:0] idx, input logic [31:0] value);
      return '{1'b1, idx, value, 16'd0, 16'd0, 1'b0, 15'd0};
   endfunction

   function automatic step_type item_row(input int tgt, input int meas);
      return '{1'b0, 2'd0, 32'd0, tgt[15:0], meas[15:0], 1'b0, 15'd0};
   endfunction

   function automatic step_type fixed_row(input int tgt, input int meas, input int drive);
      return '{1'b0, 2'd0, 32'd0, tgt[15:0], meas[15:0], 1'b1, drive[14:0]};
   endfunction

   function automatic logic [15:0] corner_temp(input int sel);
      case (sel)
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(0, 16'h0400));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [14:0] pick_limit();
      case ($urandom_range(0, 4))
         0:       return 15'd0;
         1:       return 15'h7FFF;
         2:       return 15'($urandom_range(0, 2000));
         default: return 15'($urandom);
      endcase
   endfunction

   // monitors: score results, step the model on each req transfer, shadow registers
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (drive_expected.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected rsp transfer: drive_level %0d", rsp_tdata[14:0]);
            end else begin
               drive_want = drive_expected.pop_front();
               if (rsp_tdata !== {1'b0, drive_want}) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("drive_level mismatch: expected %0d, actual %0d (tdata %h)",
                              drive_want, rsp_tdata[14:0], rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            drive_calc = next_drive(req_tdata[15:0], req_tdata[31:16]);
            drive_expected.push_back(pending_fixed ? pending_drive : drive_calc);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               pidc_pkg::REG_GAIN_PROP:   gains_model.gain_prop   = csr_pwdata[15:0];
               pidc_pkg::REG_GAIN_INTEG:  gains_model.gain_integ  = csr_pwdata[15:0];
               pidc_pkg::REG_GAIN_DERIV:  gains_model.gain_deriv  = csr_pwdata[15:0];
               pidc_pkg::REG_INTEG_LIMIT: gains_model.integ_limit = csr_pwdata[14:0];
               default: ;
            endcase
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // rsp side: random stalls, quiet stretches, one long hold-off on request
   initial begin
      int   gap;
      int   taken;
      logic hold_done;
      taken        = 0;
      hold_done    = 1'b0;
      rsp_tready   = 1'b0;
      rsp_nostall  = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         gap = rsp_nostall ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
         taken++;
         if (taken % MODE_RUN == 0)
            rsp_nostall = ($urandom_range(0, 3) == 0);
      end
   end

   // one req transfer; entered and left at a falling edge
   task automatic send_temps(input logic [15:0] tgt, input logic [15:0] meas,
                             input logic fixed, input logic [14:0] drive);
      int gap;
      gap = snd_nostall ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pending_fixed = fixed;
      pending_drive = drive;
      req_tdata  <= {meas, tgt};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // stop offering and wait until every result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (drive_expected.size() != 0) @(negedge clock);
   endtask

   // register write, setup then access; block must be idle
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      drain_results();
      repeat (PIPE_CYCLES) @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // write all four registers, random junk above each register's width
   task automatic load_gains(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] kd, input logic [14:0] lim);
      logic [31:0] wdata;
      wdata = $urandom; wdata[15:0] = kp;  csr_write(pidc_pkg::REG_GAIN_PROP, wdata);
      wdata = $urandom; wdata[15:0] = ki;  csr_write(pidc_pkg::REG_GAIN_INTEG, wdata);
      wdata = $urandom; wdata[15:0] = kd;  csr_write(pidc_pkg::REG_GAIN_DERIV, wdata);
      wdata = $urandom; wdata[14:0] = lim; csr_write(pidc_pkg::REG_INTEG_LIMIT, wdata);
   endtask

   // mostly a plant settling toward a setpoint, plus full-range and corner noise
   task automatic pick_temps(output logic [15:0] tgt, output logic [15:0] meas);
      int roll;
      int step;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         if ($urandom_range(0, 24) == 0) begin
            setpoint = $urandom_range(0, 4000);
            setpoint -= 2000;
         end
         step = $urandom_range(0, 48);
         step -= 24;
         process_val += step + (setpoint - process_val) / 16;
         if (process_val > 32767)
            process_val = 32767;
         else if (process_val < -32768)
            process_val = -32768;
         tgt  = setpoint[15:0];
         meas = process_val[15:0];
      end else if (roll < 90) begin
         tgt  = 16'($urandom);
         meas = 16'($urandom);
      end else begin
         tgt  = corner_temp($urandom_range(0, 3));
         meas = corner_temp($urandom_range(0, 3));
      end
   endtask

   // stimulus
   initial begin
      logic [15:0] tgt;
      logic [15:0] meas;
      int          n;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      pending_fixed  = 1'b0;
      pending_drive  = '0;
      snd_nostall    = 1'b0;
      hold_request   = 1'b0;
      setpoint       = 800;
      process_val    = 0;

      // after reset all gains are zero
      plan.push_back(fixed_row(160, 0, 0));
      plan.push_back(fixed_row(-32768, 32767, 0));
      // proportional gain of sixteen: saturation both ways, then plain values
      plan.push_back(cfg_row(pidc_pkg::REG_GAIN_PROP, 32'h0000_0100));
      plan.push_back(fixed_row(32767, -32768, 25600));
      plan.push_back(fixed_row(-32768, 32767, 0));
      plan.push_back(fixed_row(0, 0, 0));
      plan.push_back(fixed_row(160, 0, 2560));
      plan.push_back(fixed_row(-16, 0, 0));
      // junk above the field clears the gain; zero limit pins the integral
      plan.push_back(cfg_row(pidc_pkg::REG_GAIN_PROP, 32'hFFFF_0000));
      plan.push_back(cfg_row(pidc_pkg::REG_GAIN_INTEG, 32'h0000_FFFF));
      plan.push_back(cfg_row(pidc_pkg::REG_INTEG_LIMIT, 32'hFFFF_8000));
      plan.push_back(fixed_row(32767, -32768, 0));
      // widest limit: windup clamps at the top, then at the bottom
      plan.push_back(cfg_row(pidc_pkg::REG_INTEG_LIMIT, 32'h0000_7FFF));
      plan.push_back(fixed_row(32767, -32768, 25600));
      plan.push_back(fixed_row(-32768, 32767, 0));
      plan.push_back(item_row(0, 0));
      // derivative only, on top of a fully negative integral
      plan.push_back(cfg_row(pidc_pkg::REG_GAIN_INTEG, 32'h0000_0000));
      plan.push_back(cfg_row(pidc_pkg::REG_GAIN_DERIV, 32'h1234_FFFF));
      plan.push_back(item_row(0, 0));
      plan.push_back(fixed_row(32767, -32768, 25600));
      plan.push_back(fixed_row(32767, -32768, 0));
      // moderate gains with a tight clamp
      plan.push_back(cfg_row(pidc_pkg::REG_GAIN_PROP, 32'h0000_0080));
      plan.push_back(cfg_row(pidc_pkg::REG_GAIN_INTEG, 32'h0000_0200));
      plan.push_back(cfg_row(pidc_pkg::REG_GAIN_DERIV, 32'h0000_0010));
      plan.push_back(cfg_row(pidc_pkg::REG_INTEG_LIMIT, 32'd100));
      plan.push_back(item_row(400, 380));
      plan.push_back(item_row(400, 390));
      plan.push_back(item_row(400, 410));
      plan.push_back(item_row(-200, -180));
      plan.push_back(item_row(1000, -1000));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed plan
      foreach (plan[i]) begin
         if (plan[i].is_cfg)
            csr_write(plan[i].reg_idx, plan[i].value);
         else
            send_temps(plan[i].tgt, plan[i].meas, plan[i].fixed, plan[i].drive);
      end

      // random phases, each under its own register setting
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF);
            1:       load_gains(16'h0000, 16'h0000, 16'h0000, 15'd0);
            2:       load_gains(16'h0100, 16'h0040, 16'h0020, 15'd6400);
            default: load_gains(pick_gain(), pick_gain(), pick_gain(), pick_limit());
         endcase
         // one phase floods the block while the rsp side holds off
         if (phase == 3) begin
            hold_request = 1'b1;
            snd_nostall  = 1'b1;
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase != 3 && n % MODE_RUN == 0)
               snd_nostall = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 39) == 0)
               drain_results();
            pick_temps(tgt, meas);
            send_temps(tgt, meas, 1'b0, 15'd0);
         end
         snd_nostall = 1'b0;
      end

      // wind down
      req_tvalid <= 1'b0;
      while (drive_expected.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
